// ===== sv/mtdq_pkg.sv =====
package mtdq_pkg;

   localparam int NUM_TIMERS  = 16;
   localparam int TIME_BITS   = 48;
   localparam int SLOT_BITS   = $clog2(NUM_TIMERS);
   localparam int CNT_BITS    = $clog2(NUM_TIMERS + 1);
   localparam int MAX_RESULTS = 16;
   localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);
   localparam logic [TIME_BITS-1:0] MIN_DELAY = TIME_BITS'(100);
   localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_CANCEL = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_CANCEL   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_EXPIRED  = 3'd4;
   localparam logic [2:0] ST_NONE     = 3'd5;

   typedef struct packed {
      logic [1:0]  command;
      logic [47:0] now_us;
      logic [47:0] deadline_us;
      logic [31:0] interval_us;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  timer_slot;
      logic        last;
      logic        earliest_changed;
      logic        next_valid;
      logic [47:0] next_deadline_us;
      logic [47:0] arm_delay_us;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic scan_clr;  // start a scan
      logic scan_step; // one slot per cycle
      logic pick;      // mark best of scan as picked, log it
      logic commit;    // apply add / cancel / rearm of one logged entry
      logic pick_clr;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic found;     // expired candidate found in scan
      logic full;      // picked count reached limit
      logic commit_done;
   } sts_type;

endpackage

// ===== sv/mtdq_datapath.sv =====
module mtdq_datapath (
   input  logic              clock,
   input  logic              reset,
   input  mtdq_pkg::req_type req,
   input  mtdq_pkg::cmd_type cmd,
   output mtdq_pkg::sts_type sts,
   input  logic              emit_sel,   // 0: single result, 1: logged entry
   input  logic              emit_last,
   output mtdq_pkg::rsp_type rsp_word,
   input  logic              emit_adv
);
   import mtdq_pkg::*;

   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [NUM_TIMERS-1:0] picked_ff, picked_in;
   logic [TIME_BITS-1:0]  dl_ff  [NUM_TIMERS];
   logic [31:0]           per_ff [NUM_TIMERS];
   req_type               req_ff;

   logic [SLOT_BITS-1:0]  idx_ff;      // scan index
   logic [CNT_BITS-1:0]   scnt_ff;     // slots scanned
   logic                  bval_ff;     // best expired candidate
   logic [SLOT_BITS-1:0]  bslot_ff;
   logic [TIME_BITS-1:0]  bdl_ff;
   logic                  nval_ff;     // earliest active
   logic [TIME_BITS-1:0]  ndl_ff;
   logic                  fval_ff;     // lowest free
   logic [SLOT_BITS-1:0]  fslot_ff;

   logic [SLOT_BITS-1:0]  log_ff [MAX_RESULTS];
   logic [RES_BITS-1:0]   nlog_ff, cptr_ff, eptr_ff;
   logic                  changed_ff;
   logic [2:0]            status_ff;
   logic [SLOT_BITS-1:0]  rslot_ff;

   logic [SLOT_BITS-1:0]  idx;
   logic                  act, expd;
   logic [TIME_BITS-1:0]  dl_i;
   logic [TIME_BITS:0]    sum;
   logic [TIME_BITS-1:0]  rearm;
   logic [SLOT_BITS-1:0]  cs;
   logic [TIME_BITS-1:0]  now_t;

   assign idx   = idx_ff;
   assign act   = active_ff[idx];
   assign dl_i  = dl_ff[idx];
   assign now_t = TIME_BITS'(req_ff.now_us);
   assign expd  = act && !picked_ff[idx] && (dl_i <= now_t);
   assign cs    = log_ff[cptr_ff[SLOT_BITS-1:0]];
   assign sum   = {1'b0, dl_ff[cs]} + {{(TIME_BITS-31){1'b0}}, per_ff[cs]};
   assign rearm = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

   assign sts.scan_done   = (scnt_ff == CNT_BITS'(NUM_TIMERS));
   assign sts.found       = bval_ff;
   assign sts.full        = (nlog_ff == RES_BITS'(MAX_RESULTS));
   assign sts.commit_done = (cptr_ff == nlog_ff);

   always_comb begin
      active_in = active_ff;
      picked_in = picked_ff;
      if (cmd.pick_clr) picked_in = '0;
      if (cmd.pick) picked_in[bslot_ff] = 1'b1;
      if (cmd.commit && (cptr_ff != nlog_ff) && (per_ff[cs] == 32'd0))
         active_in[cs] = 1'b0;
      if (cmd.commit && (req_ff.command == CMD_ADD) && fval_ff)
         active_in[fslot_ff] = 1'b1;
      if (cmd.commit && (req_ff.command == CMD_CANCEL))
         active_in[SLOT_BITS'(req_ff.slot)] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         picked_ff <= '0;
         scnt_ff   <= '0;
         nlog_ff   <= '0;
         cptr_ff   <= '0;
         eptr_ff   <= '0;
      end else begin
         active_ff <= active_in;
         picked_ff <= picked_in;
         if (cmd.load) begin
            req_ff  <= req;
            nlog_ff <= '0;
            cptr_ff <= '0;
         end
         if (cmd.scan_clr) begin
            idx_ff  <= '0;
            scnt_ff <= '0;
            bval_ff <= 1'b0;
            nval_ff <= 1'b0;
            fval_ff <= 1'b0;
            eptr_ff <= '0;
         end else if (cmd.scan_step && !sts.scan_done) begin
            idx_ff  <= idx_ff + 1'b1;
            scnt_ff <= scnt_ff + 1'b1;
            if (expd && (!bval_ff || dl_i < bdl_ff)) begin
               bval_ff  <= 1'b1;
               bslot_ff <= idx;
               bdl_ff   <= dl_i;
            end
            if (act && (!nval_ff || dl_i < ndl_ff)) begin
               nval_ff <= 1'b1;
               ndl_ff  <= dl_i;
            end
            if (!act && !fval_ff) begin
               fval_ff  <= 1'b1;
               fslot_ff <= idx;
            end
         end
         if (cmd.pick) begin
            log_ff[nlog_ff[SLOT_BITS-1:0]] <= bslot_ff;
            nlog_ff <= nlog_ff + 1'b1;
         end
         if (cmd.commit) begin
            if (cptr_ff != nlog_ff) begin
               if (per_ff[cs] != 32'd0) dl_ff[cs] <= rearm;
               cptr_ff <= cptr_ff + 1'b1;
            end
            unique case (req_ff.command)
               CMD_ADD: begin
                  if (fval_ff) begin
                     dl_ff[fslot_ff]  <= TIME_BITS'(req_ff.deadline_us);
                     per_ff[fslot_ff] <= req_ff.interval_us;
                     status_ff  <= ST_ADDED;
                     rslot_ff   <= fslot_ff;
                     changed_ff <= !nval_ff || (TIME_BITS'(req_ff.deadline_us) < ndl_ff);
                  end else begin
                     status_ff  <= ST_FULL;
                     rslot_ff   <= '0;
                     changed_ff <= 1'b0;
                  end
               end
               CMD_CANCEL: begin
                  status_ff  <= active_ff[SLOT_BITS'(req_ff.slot)]
                                ? ST_CANCEL : ST_NOTFOUND;
                  rslot_ff   <= SLOT_BITS'(req_ff.slot);
                  changed_ff <= 1'b0;
               end
               default: begin
                  status_ff  <= ST_NONE;
                  rslot_ff   <= '0;
                  changed_ff <= 1'b0;
               end
            endcase
         end
         if (emit_adv) eptr_ff <= eptr_ff + 1'b1;
      end
   end

   always_comb begin
      logic [TIME_BITS-1:0] diff;
      diff = ndl_ff - now_t;
      rsp_word = '0;
      rsp_word.last             = emit_last;
      rsp_word.next_valid       = nval_ff;
      rsp_word.next_deadline_us = nval_ff ? 48'(ndl_ff) : 48'd0;
      rsp_word.arm_delay_us     = (nval_ff && ndl_ff > now_t && diff > MIN_DELAY)
                                  ? 48'(diff) : 48'(MIN_DELAY);
      if (emit_sel) begin
         rsp_word.status     = ST_EXPIRED;
         rsp_word.timer_slot = 4'(log_ff[eptr_ff[SLOT_BITS-1:0]]);
      end else begin
         rsp_word.status           = status_ff;
         rsp_word.timer_slot       = 4'(rslot_ff);
         rsp_word.earliest_changed = changed_ff;
      end
   end
endmodule

// ===== sv/mtdq_ctrl.sv =====
module mtdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        command,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtdq_pkg::cmd_type cmd,
   input  mtdq_pkg::sts_type sts,
   output logic              emit_sel,
   output logic              emit_last,
   output logic              emit_adv,
   input  logic [4:0]        nlog
);
   import mtdq_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_PICK  = 7'b0000100,
      S_COMM  = 7'b0001000,
      S_FINAL = 7'b0010000,
      S_EMIT  = 7'b0100000,
      S_ONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] cmd_ff;
   logic [4:0] ecnt_ff;
   logic       last_e;

   assign req_ready = (state_ff == S_IDLE);
   assign last_e    = (ecnt_ff + 5'd1 == nlog);

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      emit_sel  = 1'b0;
      emit_last = 1'b1;
      emit_adv  = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1; cmd.scan_clr = 1'b1; cmd.pick_clr = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               if (cmd_ff == CMD_TICK && sts.found && !sts.full) state_in = S_PICK;
               else state_in = S_COMM;
            end
         end
         S_PICK: begin
            cmd.pick = 1'b1; cmd.scan_clr = 1'b1; state_in = S_SCAN;
         end
         S_COMM: begin
            cmd.commit = 1'b1;
            if (sts.commit_done) state_in = S_FINAL;
         end
         S_FINAL: begin
            // rescan for next deadline after commits
            cmd.scan_clr = 1'b1;
            state_in = S_ONE;
         end
         S_ONE: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            emit_sel  = (cmd_ff == CMD_TICK) && (nlog != 5'd0);
            emit_last = emit_sel ? last_e : 1'b1;
            if (rsp_ready) begin
               emit_adv = 1'b1;
               if (emit_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ecnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && req_valid) begin
            cmd_ff  <= command;
            ecnt_ff <= '0;
         end
         if (emit_adv) ecnt_ff <= ecnt_ff + 5'd1;
      end
   end
endmodule

// ===== sv/multi_timer_deadline_queue.sv =====
// Sixteen-slot timer table. One transaction at a time: a request is taken only
// while the block is idle. Every request runs a sweep of the slot table
// (one slot per cycle), a commit step and a second sweep that finds the next
// deadline, after which add and cancel present their result. A tick sweeps
// once more per expired timer, logs each in a pick step and rearms or retires
// each logged timer in the commit step before its first result; the rest
// follow one per cycle while rsp_ready is high. The result stays on the port
// until taken.
module multi_timer_deadline_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mtdq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mtdq_pkg::rsp_type rsp_data
);
   import mtdq_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    emit_sel, emit_last, emit_adv;
   logic [4:0] nlog;

   // the datapath counts logged expiries; mirror it for the controller
   logic [4:0] nlog_ff;
   always_ff @(posedge clock) begin
      if (reset) nlog_ff <= '0;
      else if (cmd.load) nlog_ff <= '0;
      else if (cmd.pick) nlog_ff <= nlog_ff + 5'd1;
   end
   assign nlog = nlog_ff;

   mtdq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .command(req_data.command),
      .rsp_valid, .rsp_ready, .cmd, .sts, .emit_sel, .emit_last, .emit_adv, .nlog
   );

   mtdq_datapath u_dp (
      .clock, .reset, .req(req_data), .cmd, .sts, .emit_sel, .emit_last,
      .rsp_word(rsp_data), .emit_adv
   );
endmodule

// ===== sv/mtdq_checker.sv =====
module mtdq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mtdq_pkg::rsp_type rsp_data
);
   import mtdq_pkg::*;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while replying");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.arm_delay_us >= 48'd100) else $error("delay floor");

   a_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.next_valid |-> rsp_data.next_deadline_us == 48'd0)
      else $error("next deadline without timer");
endmodule

bind multi_timer_deadline_queue mtdq_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
